FILE: hdl/arcb_pkg.sv
package arcb_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int OUT_BITS       = 18;
    localparam int CFG_BITS       = 32;
    localparam int CFG_IDX_BITS   = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_X  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_Y  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_SQ   = 2'd2;

    localparam logic [CFG_BITS-1:0] SCALE_X_RST = 32'd3360694;
    localparam logic [CFG_BITS-1:0] SCALE_Y_RST = 32'd4483265;
    localparam logic [CFG_BITS-1:0] MIN_SQ_RST  = 32'd1;

    localparam int IN_BYTES_BITS = 32;
    localparam int OUT_DATA_BITS = 72;

    // Datapath operations issued by the controller.
    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_SCALE   = 4'd1;
    localparam logic [3:0] OP_LEN     = 4'd2;
    localparam logic [3:0] OP_SQRT    = 4'd3;
    localparam logic [3:0] OP_DIVX    = 4'd4;
    localparam logic [3:0] OP_DIVY    = 4'd5;
    localparam logic [3:0] OP_MUL     = 4'd6;
    localparam logic [3:0] OP_ROUND   = 4'd7;
    localparam logic [3:0] OP_SQ      = 4'd8;
    localparam logic [3:0] OP_STORE   = 4'd9;
    localparam logic [3:0] OP_SQRTINIT = 4'd10;
    localparam logic [3:0] OP_DIVINIT = 4'd11;
    localparam logic [3:0] OP_CMP     = 4'd12;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] sub;
    } arcb_cmd_t;

    typedef struct packed {
        logic outside;
        logic drag;
    } arcb_status_t;

endpackage

FILE: hdl/arcb_datapath.sv
module arcb_datapath #(
    parameter int COORD_BITS = arcb_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = arcb_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [arcb_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [arcb_pkg::CFG_BITS-1:0]     cfg_data,
    input  logic                              load,
    input  logic                              in_opcode,
    input  logic [COORD_BITS-1:0]             in_x,
    input  logic [COORD_BITS-1:0]             in_y,
    input  arcb_pkg::arcb_cmd_t               cmd,
    output arcb_pkg::arcb_status_t            status,
    output logic [arcb_pkg::OUT_BITS-1:0]     rot_x,
    output logic [arcb_pkg::OUT_BITS-1:0]     rot_y,
    output logic [arcb_pkg::OUT_BITS-1:0]     rot_z,
    output logic [arcb_pkg::OUT_BITS-1:0]     rot_w
);
    import arcb_pkg::*;

    localparam int VB  = FRAC_BITS + 2;
    localparam int SH  = 30 - FRAC_BITS;
    localparam int PB  = COORD_BITS + CFG_BITS;
    localparam int LB  = 2 * VB + 1;
    localparam int SQB = 2 * FRAC_BITS + 4;
    localparam int ACB = 2 * VB + 2;

    logic [CFG_BITS-1:0] scale_x_reg, scale_y_reg, min_sq_reg;
    logic [COORD_BITS-1:0] px_reg, py_reg;
    logic drag_reg;
    logic signed [VB-1:0] tx_reg, ty_reg, vx_reg, vy_reg, vz_reg;
    logic signed [VB-1:0] sx_reg, sy_reg, sz_reg;
    logic [LB-1:0] len_reg;
    logic [LB-1:0] rem_reg;
    logic [LB-1:0] root_reg;
    logic [LB-1:0] bit_reg;
    logic [LB+FRAC_BITS-1:0] num_reg;
    logic [LB+FRAC_BITS-1:0] quo_reg;
    logic signed [ACB-1:0] acc_reg [4];
    logic signed [VB+1:0] q_reg [4];
    logic [SQB-1:0] sq_reg;
    logic small_reg;

    logic [PB-1:0] prod_x, prod_y;
    logic signed [PB+1:0] rx, ry, tx_raw, ty_raw;
    logic signed [2*VB-1:0] m0, m1;
    logic signed [VB-1:0] ma, mb, mc, md;
    logic signed [VB+1:0] qsel;
    logic signed [ACB-1:0] accsel;
    logic [LB-1:0] trial;

    function automatic logic signed [VB-1:0] sat(input logic signed [PB+1:0] v);
        logic signed [PB+1:0] hi, lo;
        hi = (PB+2)'((64'sd1 <<< (FRAC_BITS + 1)) - 1);
        lo = -(PB+2)'(64'sd1 <<< (FRAC_BITS + 1));
        if (v > hi) return hi[VB-1:0];
        else if (v < lo) return lo[VB-1:0];
        else return v[VB-1:0];
    endfunction

    always_comb
    begin
        prod_x = PB'(px_reg) * PB'(scale_x_reg);
        prod_y = PB'(py_reg) * PB'(scale_y_reg);
        if (SH > 0)
        begin
            rx = (PB+2)'((prod_x + (PB'(1) << (SH > 0 ? SH - 1 : 0))) >> SH);
            ry = (PB+2)'((prod_y + (PB'(1) << (SH > 0 ? SH - 1 : 0))) >> SH);
        end
        else
        begin
            rx = (PB+2)'(prod_x);
            ry = (PB+2)'(prod_y);
        end
        tx_raw = rx - (PB+2)'(64'sd1 <<< FRAC_BITS);
        ty_raw = (PB+2)'(64'sd1 <<< FRAC_BITS) - ry;
    end

    // Operand selection for the two shared multipliers.
    always_comb
    begin
        ma = '0; mb = '0; mc = '0; md = '0;
        case (cmd.sub)
            3'd0:
            begin
                ma = sy_reg; mb = vz_reg; mc = sz_reg; md = vy_reg;
            end
            3'd1:
            begin
                ma = sz_reg; mb = vx_reg; mc = sx_reg; md = vz_reg;
            end
            3'd2:
            begin
                ma = sx_reg; mb = vy_reg; mc = sy_reg; md = vx_reg;
            end
            3'd3:
            begin
                ma = sx_reg; mb = vx_reg; mc = sy_reg; md = vy_reg;
            end
            3'd4:
            begin
                ma = sz_reg; mb = vz_reg; mc = '0; md = '0;
            end
            3'd5:
            begin
                ma = tx_reg; mb = tx_reg; mc = ty_reg; md = ty_reg;
            end
            default:
            begin
                ma = '0; mb = '0; mc = '0; md = '0;
            end
        endcase
        m0 = ma * mb;
        m1 = mc * md;
        qsel = q_reg[cmd.sub[1:0]];
        accsel = acc_reg[cmd.sub[1:0]];
        trial = root_reg + bit_reg;
    end

    logic [LB+FRAC_BITS-1:0] dshift;
    logic [LB+FRAC_BITS-1:0] dden;
    always_comb
    begin
        dshift = (LB+FRAC_BITS)'({rem_reg, num_reg[LB+FRAC_BITS-1]});
        dden = (LB+FRAC_BITS)'(root_reg);
    end

    logic signed [ACB-1:0] rnd;
    logic signed [ACB-1:0] w;
    logic signed [VB+1:0] qv;
    always_comb
    begin
        w = accsel + ACB'(64'sd1 <<< (FRAC_BITS - 1));
        rnd = w >>> FRAC_BITS;
        qv = rnd[VB+1:0];
    end

    logic signed [2*VB+3:0] qprod;
    logic [SQB-1:0] qsq;
    always_comb
    begin
        qprod = qsel * qsel;
        qsq = qprod[SQB-1:0];
    end

    logic [CFG_BITS+SQB-1:0] lhs, rhs;
    always_comb
    begin
        if (2 * FRAC_BITS >= 32)
        begin
            lhs = (CFG_BITS+SQB)'(sq_reg);
            rhs = (CFG_BITS+SQB)'(min_sq_reg) << (2 * FRAC_BITS >= 32 ? 2 * FRAC_BITS - 32 : 0);
        end
        else
        begin
            lhs = (CFG_BITS+SQB)'(sq_reg) << (2 * FRAC_BITS >= 32 ? 0 : 32 - 2 * FRAC_BITS);
            rhs = (CFG_BITS+SQB)'(min_sq_reg);
        end
    end

    assign status.outside = len_reg > (LB'(1) << (2 * FRAC_BITS));
    assign status.drag = drag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_x_reg <= SCALE_X_RST;
            scale_y_reg <= SCALE_Y_RST;
            min_sq_reg <= MIN_SQ_RST;
            sx_reg <= '0;
            sy_reg <= '0;
            sz_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SCALE_X: scale_x_reg <= cfg_data;
                    CFG_SCALE_Y: scale_y_reg <= cfg_data;
                    CFG_MIN_SQ:  min_sq_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op == OP_STORE)
            begin
                sx_reg <= vx_reg;
                sy_reg <= vy_reg;
                sz_reg <= vz_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            px_reg <= in_x;
            py_reg <= in_y;
            drag_reg <= in_opcode;
        end
        case (cmd.op)
            OP_SCALE:
            begin
                tx_reg <= sat(tx_raw);
                ty_reg <= sat(ty_raw);
            end
            OP_LEN:
            begin
                len_reg <= LB'($unsigned(m0)) + LB'($unsigned(m1));
                vx_reg <= tx_reg;
                vy_reg <= ty_reg;
                vz_reg <= '0;
            end
            OP_SQRTINIT:
            begin
                rem_reg <= status.outside ? len_reg : (LB'(1) << (2 * FRAC_BITS)) - len_reg;
                root_reg <= '0;
                bit_reg <= LB'(1) << (2 * ((LB - 1) / 2));
            end
            OP_SQRT:
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                    root_reg <= root_reg >> 1;
                bit_reg <= bit_reg >> 2;
                if (bit_reg == LB'(1) && !status.outside)
                    vz_reg <= '0;
            end
            OP_DIVINIT:
            begin
                if (!status.outside)
                    vz_reg <= VB'(root_reg);
                num_reg <= (LB+FRAC_BITS)'($unsigned(cmd.sub[0] ?
                           (ty_reg < 0 ? -ty_reg : ty_reg) :
                           (tx_reg < 0 ? -tx_reg : tx_reg))) << FRAC_BITS;
                rem_reg <= '0;
                quo_reg <= '0;
            end
            OP_DIVX, OP_DIVY:
            begin
                num_reg <= num_reg << 1;
                if (dshift >= dden)
                begin
                    rem_reg <= LB'(dshift - dden);
                    quo_reg <= {quo_reg[LB+FRAC_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= LB'(dshift);
                    quo_reg <= {quo_reg[LB+FRAC_BITS-2:0], 1'b0};
                end
                if (cmd.sub[2])
                begin
                    if (cmd.op == OP_DIVX)
                        vx_reg <= tx_reg < 0 ? -VB'(quo_reg) : VB'(quo_reg);
                    else
                        vy_reg <= ty_reg < 0 ? -VB'(quo_reg) : VB'(quo_reg);
                end
            end
            OP_MUL:
            begin
                if (cmd.sub == 3'd4)
                    acc_reg[3] <= acc_reg[3] + ACB'(m0);
                else if (cmd.sub == 3'd3)
                    acc_reg[3] <= ACB'(m0) + ACB'(m1);
                else
                    acc_reg[cmd.sub[1:0]] <= ACB'(m0) - ACB'(m1);
            end
            OP_ROUND:
            begin
                q_reg[cmd.sub[1:0]] <= qv;
                if (cmd.sub == 3'd0)
                    sq_reg <= '0;
            end
            OP_SQ:
                sq_reg <= sq_reg + qsq;
            OP_CMP:
                small_reg <= lhs <= rhs;
            default: ;
        endcase
    end

    assign rot_x = small_reg ? '0 : OUT_BITS'(q_reg[0]);
    assign rot_y = small_reg ? '0 : OUT_BITS'(q_reg[1]);
    assign rot_z = small_reg ? '0 : OUT_BITS'(q_reg[2]);
    assign rot_w = small_reg ? '0 : OUT_BITS'(q_reg[3]);

endmodule

FILE: hdl/arcb_ctrl.sv
module arcb_ctrl #(
    parameter int COORD_BITS = arcb_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = arcb_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   load,
    output logic                   out_valid,
    input  logic                   out_ready,
    output arcb_pkg::arcb_cmd_t    cmd,
    input  arcb_pkg::arcb_status_t status
);
    import arcb_pkg::*;

    localparam int LB = 2 * (FRAC_BITS + 2) + 1;
    localparam int SQ_STEPS = (LB + 1) / 2;
    localparam int DIV_STEPS = LB + FRAC_BITS;
    localparam int CB = 7;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCALE = 4'd1;
    localparam logic [3:0] S_LEN   = 4'd2;
    localparam logic [3:0] S_SQI   = 4'd3;
    localparam logic [3:0] S_SQRT  = 4'd4;
    localparam logic [3:0] S_DIVI  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_END   = 4'd7;
    localparam logic [3:0] S_MUL   = 4'd8;
    localparam logic [3:0] S_RND   = 4'd9;
    localparam logic [3:0] S_SQ    = 4'd10;
    localparam logic [3:0] S_CMP   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [CB-1:0] cnt_reg, cnt_next;
    logic axis_reg, axis_next;

    assign in_ready = state_reg == S_IDLE;
    assign load = in_valid && in_ready;
    assign out_valid = state_reg == S_OUT;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        axis_next = axis_reg;
        cmd.op = OP_NONE;
        cmd.sub = '0;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_SCALE;
            S_SCALE:
            begin
                cmd.op = OP_SCALE;
                state_next = S_LEN;
            end
            S_LEN:
            begin
                cmd.op = OP_LEN;
                cmd.sub = 3'd5;
                state_next = S_SQI;
            end
            S_SQI:
            begin
                cmd.op = OP_SQRTINIT;
                cnt_next = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op = OP_SQRT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CB'(SQ_STEPS - 1))
                begin
                    axis_next = 1'b0;
                    state_next = S_DIVI;
                end
            end
            S_DIVI:
            begin
                cmd.op = OP_DIVINIT;
                cmd.sub = {2'b00, axis_reg};
                cnt_next = '0;
                state_next = status.outside ? S_DIV : S_END;
            end
            S_DIV:
            begin
                cmd.op = axis_reg ? OP_DIVY : OP_DIVX;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CB'(DIV_STEPS))
                begin
                    cmd.sub = 3'd4;
                    if (axis_reg)
                        state_next = S_END;
                    else
                    begin
                        axis_next = 1'b1;
                        state_next = S_DIVI;
                    end
                end
            end
            S_END:
            begin
                cnt_next = '0;
                if (status.drag)
                    state_next = S_MUL;
                else
                begin
                    cmd.op = OP_STORE;
                    state_next = S_IDLE;
                end
            end
            S_MUL:
            begin
                cmd.op = OP_MUL;
                cmd.sub = cnt_reg[2:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CB'(4))
                begin
                    cnt_next = '0;
                    state_next = S_RND;
                end
            end
            S_RND:
            begin
                cmd.op = OP_ROUND;
                cmd.sub = cnt_reg[2:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CB'(3))
                begin
                    cnt_next = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cmd.op = OP_SQ;
                cmd.sub = cnt_reg[2:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CB'(2))
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.op = OP_CMP;
                state_next = S_OUT;
            end
            S_OUT:
                if (out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            axis_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            axis_reg <= axis_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");
    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> state_reg == S_SCALE)
        else $error("accepted item did not start");

endmodule

FILE: hdl/arcball_rotation.sv
// Arcball rotation unit. Each input item is a click (opcode 0) or a drag (opcode 1) at a
// pixel position; a click stores the mapped sphere vector and returns nothing, a drag
// returns one rotation (cross product x, y, z and dot product w, signed Q2.16). Items are
// taken one at a time: a new item is taken only once the last is finished. Inside the
// unit circle the 19-step square root sets the time per item, and outside two bit-serial
// divisions dominate; a drag adds the shared two-multiplier product sequence and holds
// its result until the receiver takes it.
module arcball_rotation #(
    parameter int COORD_BITS = arcb_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = arcb_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [arcb_pkg::IN_BYTES_BITS-1:0] s_axis_tdata, // pointer_x, pointer_y
    input  logic                              s_axis_tuser, // opcode
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [arcb_pkg::OUT_DATA_BITS-1:0] m_axis_tdata, // rot_x, rot_y, rot_z, rot_w
    input  logic                              cfg_we,
    input  logic [arcb_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [arcb_pkg::CFG_BITS-1:0]     cfg_data
);
    import arcb_pkg::*;

    arcb_cmd_t cmd;
    arcb_status_t status;
    logic load;
    logic [OUT_BITS-1:0] rx, ry, rz, rw;

    arcb_ctrl #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .load(load),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .cmd(cmd), .status(status)
    );

    arcb_datapath #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .load(load), .in_opcode(s_axis_tuser),
        .in_x(s_axis_tdata[COORD_BITS-1:0]),
        .in_y(s_axis_tdata[COORD_BITS +: COORD_BITS]),
        .cmd(cmd), .status(status),
        .rot_x(rx), .rot_y(ry), .rot_z(rz), .rot_w(rw)
    );

    assign m_axis_tdata = {rw, rz, ry, rx};

endmodule

FILE: tb/sv/tb_arcball_rotation.sv
`timescale 1ns / 100ps

module tb_arcball_rotation;

    import arcb_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
    localparam logic OP_CLICK = 1'b0;
    localparam logic OP_DRAG  = 1'b1;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 250;
    localparam int HOLD_CYCLES    = 3000;

    typedef struct {
        logic        op;
        logic [11:0] px;
        logic [11:0] py;
        logic        typed;
        logic [71:0] rot;
    } pointer_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_BYTES_BITS-1:0] s_axis_tdata;
    logic                     s_axis_tuser;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_BITS-1:0]      cfg_data;

    logic [31:0]        scale_x_reg;
    logic [31:0]        scale_y_reg;
    logic [31:0]        min_sq_reg;
    logic signed [17:0] start_x;
    logic signed [17:0] start_y;
    logic signed [17:0] start_z;

    logic [71:0]  rotations_due[$];
    pointer_row_t typed_due[$];
    int           errors;
    int           quiet_cycles;
    bit           sender_idles;
    bit           receiver_idles;
    bit           hold_request;

    arcball_rotation u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint clamp_q2(longint v);
        if (v > 131071)
            return 131071;
        if (v < -131072)
            return -131072;
        return v;
    endfunction

    function automatic longint scaled_coord(logic [11:0] c, logic [31:0] s);
        longint unsigned p;
        p = longint'(c) * longint'(s);
        return longint'((p + 64'd8192) >> 14);
    endfunction

    function automatic longint unit_divide(longint t, longint unsigned r);
        longint unsigned m;
        longint q;
        m = (t < 0) ? -t : t;
        q = longint'((m << 16) / r);
        return (t < 0) ? -q : q;
    endfunction

    function automatic longint round_q(longint v);
        return (v + 32768) >>> 16;
    endfunction

    task automatic sphere_point(input logic [11:0] px, input logic [11:0] py,
                                output longint vx, output longint vy, output longint vz);
        longint tx;
        longint ty;
        longint unsigned len;
        longint unsigned r;
        tx = clamp_q2(scaled_coord(px, scale_x_reg) - 65536);
        ty = clamp_q2(65536 - scaled_coord(py, scale_y_reg));
        len = tx * tx + ty * ty;
        if (len > 64'h1_0000_0000)
        begin
            r = int_sqrt(len);
            vx = unit_divide(tx, r);
            vy = unit_divide(ty, r);
            vz = 0;
        end
        else
        begin
            vx = tx;
            vy = ty;
            vz = longint'(int_sqrt(64'h1_0000_0000 - len));
        end
    endtask

    task automatic drag_rotation(input logic [11:0] px, input logic [11:0] py,
                                 output logic [71:0] rot);
        longint bx, by, bz, ax, ay, az, cx, cy, cz, dw;
        longint unsigned sq;
        sphere_point(px, py, bx, by, bz);
        ax = start_x;
        ay = start_y;
        az = start_z;
        cx = round_q(ay * bz - az * by);
        cy = round_q(az * bx - ax * bz);
        cz = round_q(ax * by - ay * bx);
        dw = round_q(ax * bx + ay * by + az * bz);
        sq = cx * cx + cy * cy + cz * cz;
        if (sq <= longint'(min_sq_reg))
            rot = '0;
        else
            rot = {dw[17:0], cz[17:0], cy[17:0], cx[17:0]};
    endtask

    task automatic report(input string field, input logic [17:0] got, input logic [17:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, $signed(got),
                 $signed(want), $realtime);
        errors++;
    endtask

    // Input side: a taken click updates the start vector and a taken drag queues its rotation.
    always @(posedge clk)
    begin : input_monitor
        longint vx, vy, vz;
        logic [71:0] rot;
        pointer_row_t row;
        bit have_row;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            quiet_cycles = 0;
            have_row = 1'b0;
            if (typed_due.size() != 0)
            begin
                row = typed_due.pop_front();
                have_row = 1'b1;
            end
            if (s_axis_tuser == OP_CLICK)
            begin
                sphere_point(s_axis_tdata[11:0], s_axis_tdata[23:12], vx, vy, vz);
                start_x = vx[17:0];
                start_y = vy[17:0];
                start_z = vz[17:0];
            end
            else
            begin
                drag_rotation(s_axis_tdata[11:0], s_axis_tdata[23:12], rot);
                if (have_row && row.typed)
                    rot = row.rot;
                rotations_due.push_back(rot);
            end
        end
    end

    always @(posedge clk)
    begin : output_monitor
        logic [71:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            quiet_cycles = 0;
            if (rotations_due.size() == 0)
            begin
                $display("unexpected rotation %h at %0t", m_axis_tdata, $realtime);
                errors++;
            end
            else
            begin
                want = rotations_due.pop_front();
                if (m_axis_tdata[17:0] !== want[17:0])
                    report("rot_x", m_axis_tdata[17:0], want[17:0]);
                if (m_axis_tdata[35:18] !== want[35:18])
                    report("rot_y", m_axis_tdata[35:18], want[35:18]);
                if (m_axis_tdata[53:36] !== want[53:36])
                    report("rot_z", m_axis_tdata[53:36], want[53:36]);
                if (m_axis_tdata[71:54] !== want[71:54])
                    report("rot_w", m_axis_tdata[71:54], want[71:54]);
            end
        end
    end

    always @(posedge clk)
    begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout with %0d rotations outstanding", rotations_due.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : receiver
        int n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            n = receiver_idles ? $urandom_range(0, 18) : 0;
            if (n > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    task automatic send_pointer(input logic op, input logic [11:0] px, input logic [11:0] py);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {8'b0, py, px};
        do
            @(posedge clk);
        while (!s_axis_tready);
        gap = sender_idles ? $urandom_range(0, 18) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (rotations_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SCALE_X: scale_x_reg = val;
            CFG_SCALE_Y: scale_y_reg = val;
            CFG_MIN_SQ:  min_sq_reg  = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        int span_x;
        int span_y;
        logic [11:0] px;
        logic [11:0] py;
        span_x = $urandom_range(16, 4095);
        span_y = $urandom_range(16, 4095);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                px = 12'($urandom_range(0, span_x));
                py = 12'($urandom_range(0, span_y));
            end
            else
            begin
                px = 12'($urandom);
                py = 12'($urandom);
            end
            send_pointer(($urandom_range(0, 9) < 3) ? OP_CLICK : OP_DRAG, px, py);
        end
    endtask

    function automatic logic [31:0] scale_for(int span);
        return 32'((64'd1 << 31) / span);
    endfunction

    pointer_row_t directed[] = '{
        '{OP_DRAG,  12'd0,    12'd0,    1'b1, 72'd0},
        '{OP_DRAG,  12'd4095, 12'd4095, 1'b1, 72'd0},
        '{OP_CLICK, 12'd0,    12'd0,    1'b0, 72'd0},
        '{OP_DRAG,  12'd0,    12'd0,    1'b1, 72'd0},
        '{OP_DRAG,  12'd4095, 12'd0,    1'b0, 72'd0},
        '{OP_DRAG,  12'd640,  12'd479,  1'b0, 72'd0},
        '{OP_CLICK, 12'd640,  12'd479,  1'b0, 72'd0},
        '{OP_DRAG,  12'd640,  12'd479,  1'b1, 72'd0},
        '{OP_DRAG,  12'd700,  12'd400,  1'b0, 72'd0},
        '{OP_DRAG,  12'd1279, 12'd958,  1'b0, 72'd0},
        '{OP_CLICK, 12'd4095, 12'd4095, 1'b0, 72'd0},
        '{OP_DRAG,  12'd0,    12'd4095, 1'b0, 72'd0},
        '{OP_DRAG,  12'd2730, 12'd1365, 1'b0, 72'd0},
        '{OP_CLICK, 12'd1,    12'd958,  1'b0, 72'd0},
        '{OP_DRAG,  12'd1279, 12'd0,    1'b0, 72'd0},
        '{OP_DRAG,  12'd641,  12'd480,  1'b0, 72'd0},
        '{OP_CLICK, 12'd320,  12'd240,  1'b0, 72'd0},
        '{OP_DRAG,  12'd960,  12'd720,  1'b0, 72'd0},
        '{OP_DRAG,  12'd2048, 12'd2048, 1'b0, 72'd0}
    };

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tuser   = 1'b0;
        s_axis_tdata   = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        errors         = 0;
        quiet_cycles   = 0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        hold_request   = 1'b0;
        scale_x_reg    = SCALE_X_RST;
        scale_y_reg    = SCALE_Y_RST;
        min_sq_reg     = MIN_SQ_RST;
        start_x        = '0;
        start_y        = '0;
        start_z        = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            typed_due.push_back(directed[i]);
            send_pointer(directed[i].op, directed[i].px, directed[i].py);
        end
        settle();

        write_reg(CFG_SCALE_X, 32'd0);
        write_reg(CFG_SCALE_Y, 32'hFFFF_FFFF);
        write_reg(CFG_MIN_SQ, 32'd0);
        write_reg(CFG_SPARE, 32'hFFFF_FFFF);
        random_phase(30);
        settle();

        write_reg(CFG_SCALE_X, 32'hFFFF_FFFF);
        write_reg(CFG_SCALE_Y, 32'd0);
        write_reg(CFG_MIN_SQ, 32'hFFFF_FFFF);
        random_phase(20);
        settle();

        write_reg(CFG_SCALE_X, scale_for(639));
        write_reg(CFG_SCALE_Y, scale_for(479));
        write_reg(CFG_MIN_SQ, 32'd0);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        random_phase(60);
        settle();

        sender_idles = 1'b0;
        hold_request = 1'b1;
        receiver_idles = 1'b1;
        random_phase(40);
        settle();

        for (int p = 0; p < 4; p++)
        begin
            sender_idles = 1'b1;
            write_reg(CFG_SCALE_X, scale_for($urandom_range(15, 4095)));
            write_reg(CFG_SCALE_Y, scale_for($urandom_range(15, 4095)));
            write_reg(CFG_MIN_SQ, $urandom_range(0, 1 << 20));
            random_phase(60);
            settle();
        end

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
